// ----- rtl/core/apsp_pkg.sv -----
`timescale 1ns / 1ps

package apsp_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam int NODE_W     = 4;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 5'd16;
  localparam logic               UNDIRECTED_RST = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_EDGE    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 1'b0,
    CFG_UNDIRECTED = 1'b1
  } cfg_index_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_READ   = 1'b1
  } result_kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_FWD,
    ST_EDGE_REV,
    ST_READ_ISSUE,
    ST_READ_DATA,
    ST_RLX_RD,
    ST_RLX_SUM,
    ST_RLX_UPD,
    ST_NEG_RD,
    ST_NEG_CHK,
    ST_RESP
  } state_e;

  // One matrix entry: the infinity mark sits above the distance.
  typedef struct packed {
    logic                     inf;
    logic signed [DIST_W-1:0] value;
  } entry_t;

  typedef struct packed {
    result_kind_e             kind;
    logic                     neg;
    logic                     inf;
    logic signed [DIST_W-1:0] distance;
  } result_t;

endpackage

// ----- rtl/core/apsp_mem.sv -----
`timescale 1ns / 1ps

module apsp_mem #(
  parameter int DEPTH  = apsp_pkg::MAX_NODES_DEF * apsp_pkg::MAX_NODES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  apsp_pkg::entry_t    wdata_i,
  input  logic [ADDR_W-1:0]   raddr_a_i,
  input  logic [ADDR_W-1:0]   raddr_b_i,
  output apsp_pkg::entry_t    rdata_a_o,
  output apsp_pkg::entry_t    rdata_b_o
);

  apsp_pkg::entry_t mem_q [DEPTH];
  apsp_pkg::entry_t rdata_a_q;
  apsp_pkg::entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- rtl/core/apsp_relax.sv -----
`timescale 1ns / 1ps

module apsp_relax (
  input  logic             clk_i,
  input  logic             load_i,
  input  apsp_pkg::entry_t ik_i,
  input  apsp_pkg::entry_t kj_i,
  input  apsp_pkg::entry_t ij_i,
  output logic             update_o,
  output apsp_pkg::entry_t cand_o
);

  localparam int DW = apsp_pkg::DIST_W;

  logic signed [DW:0]   sum;
  logic signed [DW-1:0] sat_d;
  logic signed [DW-1:0] cand_q;
  logic                 skip_q;

  // The 33-bit sum overflows the 32-bit range when its top two bits differ.
  always_comb begin
    sum = {ik_i.value[DW-1], ik_i.value} + {kj_i.value[DW-1], kj_i.value};
    if (sum[DW] != sum[DW-1]) begin
      sat_d = sum[DW] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
    end else begin
      sat_d = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cand_q <= sat_d;
      skip_q <= ik_i.inf | kj_i.inf;
    end
  end

  assign update_o = !skip_q && (ij_i.inf || ($signed(cand_q) < $signed(ij_i.value)));
  assign cand_o   = '{inf: 1'b0, value: cand_q};

endmodule

// ----- rtl/core/apsp_seq.sv -----
`timescale 1ns / 1ps

module apsp_seq #(
  parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF,
  parameter int ADDR_W    = $clog2(MAX_NODES * MAX_NODES)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [apsp_pkg::COUNT_W-1:0]         node_count_i,
  input  logic                                 undirected_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  apsp_pkg::opcode_e                    in_op_i,
  input  logic [apsp_pkg::NODE_W-1:0]          in_from_i,
  input  logic [apsp_pkg::NODE_W-1:0]          in_to_i,
  input  logic signed [apsp_pkg::WEIGHT_W-1:0] in_weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output apsp_pkg::result_t                    out_result_o,
  output logic                                 mem_we_o,
  output logic [ADDR_W-1:0]                    mem_waddr_o,
  output apsp_pkg::entry_t                     mem_wdata_o,
  output logic [ADDR_W-1:0]                    mem_raddr_a_o,
  output logic [ADDR_W-1:0]                    mem_raddr_b_o,
  input  apsp_pkg::entry_t                     mem_rdata_a_i,
  output logic                                 relax_load_o,
  input  logic                                 relax_update_i,
  input  apsp_pkg::entry_t                     relax_cand_i
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int DW    = apsp_pkg::DIST_W;
  localparam int WW    = apsp_pkg::WEIGHT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  apsp_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;

  logic [apsp_pkg::NODE_W-1:0]  from_q, to_q;
  logic signed [WW-1:0]         weight_q;
  apsp_pkg::result_t            res_q, res_d;
  apsp_pkg::result_t            out_res_q, out_res_d;
  logic                         out_valid_q, out_valid_d;

  logic [CNT_W-1:0] n_eff;
  logic             accept;
  logic             k_last, i_last, j_last;
  logic             in_range;
  logic [IDX_W-1:0] from_idx, to_idx;
  logic             out_free;
  logic             read_inf;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_NODES) + ADDR_W'(c);
  endfunction

  // A node count above the matrix size acts as the matrix size.
  assign n_eff = (32'(node_count_i) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_i);

  assign k_last = (CNT_W'(k_q) + CNT_W'(1)) == n_eff;
  assign i_last = (CNT_W'(i_q) + CNT_W'(1)) == n_eff;
  assign j_last = (CNT_W'(j_q) + CNT_W'(1)) == n_eff;

  assign in_range = (32'(from_q) < 32'(MAX_NODES)) && (32'(to_q) < 32'(MAX_NODES));
  assign from_idx = IDX_W'(from_q);
  assign to_idx   = IDX_W'(to_q);

  assign in_ready_o = (state_q == apsp_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign read_inf   = !in_range || mem_rdata_a_i.inf;

  always_comb begin : p_next
    state_d = state_q;
    unique case (state_q)
      apsp_pkg::ST_CLEAR: begin
        if (i_q == LAST_IDX && j_q == LAST_IDX) begin
          state_d = apsp_pkg::ST_IDLE;
        end
      end
      apsp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            apsp_pkg::OP_CLEAR:   state_d = apsp_pkg::ST_CLEAR;
            apsp_pkg::OP_EDGE:    state_d = apsp_pkg::ST_EDGE_FWD;
            apsp_pkg::OP_COMPUTE: begin
              state_d = (n_eff == '0) ? apsp_pkg::ST_RESP : apsp_pkg::ST_RLX_RD;
            end
            apsp_pkg::OP_READ:    state_d = apsp_pkg::ST_READ_ISSUE;
            default:              state_d = apsp_pkg::ST_IDLE;
          endcase
        end
      end
      apsp_pkg::ST_EDGE_FWD: begin
        state_d = undirected_i ? apsp_pkg::ST_EDGE_REV : apsp_pkg::ST_IDLE;
      end
      apsp_pkg::ST_EDGE_REV:   state_d = apsp_pkg::ST_IDLE;
      apsp_pkg::ST_READ_ISSUE: state_d = apsp_pkg::ST_READ_DATA;
      apsp_pkg::ST_READ_DATA:  state_d = apsp_pkg::ST_RESP;
      apsp_pkg::ST_RLX_RD:     state_d = apsp_pkg::ST_RLX_SUM;
      apsp_pkg::ST_RLX_SUM:    state_d = apsp_pkg::ST_RLX_UPD;
      apsp_pkg::ST_RLX_UPD: begin
        state_d = (k_last && i_last && j_last) ? apsp_pkg::ST_NEG_RD
                                               : apsp_pkg::ST_RLX_RD;
      end
      apsp_pkg::ST_NEG_RD:     state_d = apsp_pkg::ST_NEG_CHK;
      apsp_pkg::ST_NEG_CHK: begin
        state_d = i_last ? apsp_pkg::ST_RESP : apsp_pkg::ST_NEG_RD;
      end
      apsp_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = apsp_pkg::ST_IDLE;
        end
      end
      default: state_d = apsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin : p_out
    k_d           = k_q;
    i_d           = i_q;
    j_d           = j_q;
    res_d         = res_q;
    out_res_d     = out_res_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    mem_we_o      = 1'b0;
    mem_waddr_o   = addr_of(i_q, j_q);
    mem_wdata_o   = '{inf: 1'b0, value: '0};
    mem_raddr_a_o = addr_of(i_q, j_q);
    mem_raddr_b_o = addr_of(k_q, j_q);
    relax_load_o  = 1'b0;

    unique case (state_q)
      apsp_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '{inf: (i_q != j_q), value: '0};
        if (j_q == LAST_IDX) begin
          j_d = '0;
          i_d = i_q + IDX_W'(1);
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      apsp_pkg::ST_IDLE: begin
        if (accept) begin
          k_d   = '0;
          i_d   = '0;
          j_d   = '0;
          res_d = '{kind: apsp_pkg::KIND_STATUS, neg: 1'b0, inf: 1'b0,
                    distance: '0};
        end
      end
      apsp_pkg::ST_EDGE_FWD: begin
        mem_we_o    = in_range;
        mem_waddr_o = addr_of(from_idx, to_idx);
        mem_wdata_o = '{inf: 1'b0, value: {{(DW-WW){weight_q[WW-1]}}, weight_q}};
      end
      apsp_pkg::ST_EDGE_REV: begin
        mem_we_o    = in_range;
        mem_waddr_o = addr_of(to_idx, from_idx);
        mem_wdata_o = '{inf: 1'b0, value: {{(DW-WW){weight_q[WW-1]}}, weight_q}};
      end
      apsp_pkg::ST_READ_ISSUE: begin
        mem_raddr_a_o = addr_of(from_idx, to_idx);
      end
      apsp_pkg::ST_READ_DATA: begin
        res_d = '{kind: apsp_pkg::KIND_READ, neg: 1'b0, inf: read_inf,
                  distance: read_inf ? '0 : mem_rdata_a_i.value};
      end
      apsp_pkg::ST_RLX_RD: begin
        mem_raddr_a_o = addr_of(i_q, k_q);
        mem_raddr_b_o = addr_of(k_q, j_q);
      end
      apsp_pkg::ST_RLX_SUM: begin
        // Row and column operands arrive now; the entry itself is fetched next.
        relax_load_o  = 1'b1;
        mem_raddr_a_o = addr_of(i_q, j_q);
      end
      apsp_pkg::ST_RLX_UPD: begin
        mem_we_o    = relax_update_i;
        mem_waddr_o = addr_of(i_q, j_q);
        mem_wdata_o = relax_cand_i;
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d = '0;
            k_d = k_q + IDX_W'(1);
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      apsp_pkg::ST_NEG_RD: begin
        mem_raddr_a_o = addr_of(i_q, i_q);
      end
      apsp_pkg::ST_NEG_CHK: begin
        res_d.neg = res_q.neg | (!mem_rdata_a_i.inf && mem_rdata_a_i.value[DW-1]);
        i_d       = i_q + IDX_W'(1);
      end
      apsp_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apsp_pkg::ST_CLEAR;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      from_q   <= in_from_i;
      to_q     <= in_to_i;
      weight_q <= in_weight_i;
    end
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_res_q;

endmodule

// ----- rtl/core/all_pairs_shortest_path_top.sv -----
`timescale 1ns / 1ps

// All-pairs shortest path engine over a MAX_NODES x MAX_NODES distance matrix held in an
// on-chip RAM, each entry a 32-bit signed distance plus an infinity mark. Requests select
// an operation in s_axis_tuser: clear (one entry per cycle), edge write (a second write
// for the reverse edge when undirected), read and compute, which runs Floyd-Warshall on
// one shared saturating adder and comparator; each relaxation reads the row and column
// operands, then the entry, then writes it back, as set by the RAM's two read ports and
// single write port, over n = node_count nodes. Reads and computes each return one
// result; the others return none. After reset the RAM is swept to infinity with a zero
// diagonal before the first request is accepted. s_axis_tready is high only between
// requests, and a waiting result does not block the next request.
module all_pairs_shortest_path_top #(
  parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [apsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [apsp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,   // from_node, to_node, edge_weight
  input  logic [1:0]                         s_axis_tuser,   // opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,   // distance, is_infinite,
                                                             // negative_cycle, zero fill
  output logic [0:0]                         m_axis_tuser    // result_kind
);

  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [apsp_pkg::COUNT_W-1:0] node_count_q;
  logic                         undirected_q;

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  apsp_pkg::entry_t        mem_wdata;
  logic [ADDR_W-1:0]       mem_raddr_a;
  logic [ADDR_W-1:0]       mem_raddr_b;
  apsp_pkg::entry_t        mem_rdata_a;
  apsp_pkg::entry_t        mem_rdata_b;
  logic                    relax_load;
  logic                    relax_update;
  apsp_pkg::entry_t        relax_cand;
  apsp_pkg::result_t       result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= apsp_pkg::NODE_COUNT_RST;
      undirected_q <= apsp_pkg::UNDIRECTED_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == apsp_pkg::CFG_NODE_COUNT) begin
        node_count_q <= cfg_wdata_i;
      end else if (cfg_index_i == apsp_pkg::CFG_UNDIRECTED) begin
        undirected_q <= cfg_wdata_i[0];
      end
    end
  end

  apsp_seq #(
    .MAX_NODES (MAX_NODES),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .node_count_i   (node_count_q),
    .undirected_i   (undirected_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (apsp_pkg::opcode_e'(s_axis_tuser)),
    .in_from_i      (s_axis_tdata[3:0]),
    .in_to_i        (s_axis_tdata[7:4]),
    .in_weight_i    (s_axis_tdata[23:8]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_result_o   (result),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_a_o  (mem_raddr_a),
    .mem_raddr_b_o  (mem_raddr_b),
    .mem_rdata_a_i  (mem_rdata_a),
    .relax_load_o   (relax_load),
    .relax_update_i (relax_update),
    .relax_cand_i   (relax_cand)
  );

  apsp_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Port A carries the row operand during the operand fetch, port B the column operand.
  apsp_relax u_relax (
    .clk_i    (clk_i),
    .load_i   (relax_load),
    .ik_i     (mem_rdata_a),
    .kj_i     (mem_rdata_b),
    .ij_i     (mem_rdata_a),
    .update_o (relax_update),
    .cand_o   (relax_cand)
  );

  assign m_axis_tdata = {6'b0, result.neg, result.inf, result.distance};
  assign m_axis_tuser = result.kind;

endmodule

// ----- rtl/core/apsp_checker.sv -----
`timescale 1ns / 1ps

module apsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // The engine is never ready in the cycle right after it takes a request.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine ready right after taking a request");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == apsp_pkg::KIND_STATUS) |-> m_axis_tdata[32:0] == '0)
    else $error("compute status carries distance or infinity");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == apsp_pkg::KIND_READ)
      |-> !m_axis_tdata[33] && (!m_axis_tdata[32] || m_axis_tdata[31:0] == '0))
    else $error("read result flags inconsistent");

endmodule

bind all_pairs_shortest_path_top apsp_checker u_apsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import apsp_pkg::*;

  localparam int NODES         = MAX_NODES_DEF;
  localparam int CLK_PERIOD    = 4;
  localparam int RANDOM_ITEMS  = 100;
  localparam int SETTLE_CYCLES = NODES * NODES + 16;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic               is_cfg;
    cfg_index_e         reg_index;
    logic [4:0]         reg_value;
    opcode_e            op;
    logic [3:0]         src;
    logic [3:0]         dst;
    logic signed [15:0] w;
    logic               typed;
    result_t            want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_NODE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // from_node, to_node, edge_weight
  logic [1:0]            s_axis_tuser = OP_CLEAR;  // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;  // distance, is_infinite, negative_cycle, zero fill
  logic [0:0]            m_axis_tuser;  // result_kind

  // Expected view of the distance matrix and registers.
  logic signed [31:0] path_dist [NODES][NODES];
  logic               path_inf [NODES][NODES];
  logic [4:0]         active_nodes;
  logic               both_ways;

  result_t     pending_results[$];
  plan_row_t   directed_plan[$];
  int          items_sent = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 84;

  all_pairs_shortest_path_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_paths();
    for (int r = 0; r < NODES; r++) begin
      for (int c = 0; c < NODES; c++) begin
        path_dist[r][c] = '0;
        path_inf[r][c]  = (r != c);
      end
    end
  endfunction

  // Applies one request to the expected matrix; returns 1 when it yields a result.
  function automatic logic predict_request(input opcode_e op, input logic [3:0] src,
                                           input logic [3:0] dst,
                                           input logic signed [15:0] w,
                                           output result_t res);
    int                 n;
    longint             s;
    logic signed [31:0] cand;
    res.kind     = KIND_STATUS;
    res.neg      = 1'b0;
    res.inf      = 1'b0;
    res.distance = '0;
    case (op)
      OP_CLEAR: begin
        clear_paths();
        return 1'b0;
      end
      OP_EDGE: begin
        path_dist[src][dst] = {{16{w[15]}}, w};
        path_inf[src][dst]  = 1'b0;
        if (both_ways) begin
          path_dist[dst][src] = {{16{w[15]}}, w};
          path_inf[dst][src]  = 1'b0;
        end
        return 1'b0;
      end
      OP_COMPUTE: begin
        n = (active_nodes > NODES) ? NODES : int'(active_nodes);
        for (int k = 0; k < n; k++) begin
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              if (!path_inf[i][k] && !path_inf[k][j]) begin
                s = longint'(path_dist[i][k]) + longint'(path_dist[k][j]);
                if (s > longint'(DIST_MAX)) cand = DIST_MAX;
                else if (s < longint'(DIST_MIN)) cand = DIST_MIN;
                else cand = s[31:0];
                if (path_inf[i][j] || cand < path_dist[i][j]) begin
                  path_dist[i][j] = cand;
                  path_inf[i][j]  = 1'b0;
                end
              end
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          if (!path_inf[i][i] && path_dist[i][i] < 0) res.neg = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        res.kind = KIND_READ;
        if (path_inf[src][dst]) res.inf = 1'b1;
        else res.distance = path_dist[src][dst];
        return 1'b1;
      end
    endcase
  endfunction

  function automatic plan_row_t item_row(input opcode_e op, input logic [3:0] src,
                                         input logic [3:0] dst, input int w);
    plan_row_t row;
    row.is_cfg        = 1'b0;
    row.reg_index     = CFG_NODE_COUNT;
    row.reg_value     = '0;
    row.op            = op;
    row.src           = src;
    row.dst           = dst;
    row.w             = w[15:0];
    row.typed         = 1'b0;
    row.want.kind     = (op == OP_READ) ? KIND_READ : KIND_STATUS;
    row.want.neg      = 1'b0;
    row.want.inf      = 1'b0;
    row.want.distance = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input opcode_e op, input logic [3:0] src,
                                            input logic [3:0] dst, input int w,
                                            input int want_dist, input logic inf,
                                            input logic neg);
    plan_row_t row;
    row               = item_row(op, src, dst, w);
    row.typed         = 1'b1;
    row.want.distance = want_dist;
    row.want.inf      = inf;
    row.want.neg      = neg;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_index_e idx, input logic [4:0] value);
    plan_row_t row;
    row           = item_row(OP_CLEAR, 4'd0, 4'd0, 0);
    row.is_cfg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  function automatic logic [3:0] pick_node(input int nodes);
    if ($urandom_range(99) < 85) return 4'($urandom_range(nodes - 1));
    return 4'($urandom_range(15));
  endfunction

  // Waits until every result is back and any clear still running has finished.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_index_e idx, input logic [4:0] value);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NODE_COUNT) active_nodes = value;
    else both_ways = value[0];
  endtask

  task automatic send_request(input opcode_e op, input logic [3:0] src,
                              input logic [3:0] dst, input logic signed [15:0] w,
                              input logic typed, input result_t typed_res);
    result_t res;
    logic    has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, dst, src};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    has_res = predict_request(op, src, dst, w, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Now and then a random request of any kind goes out ahead of the intended one.
  task automatic send_item(input opcode_e op, input logic [3:0] src,
                           input logic [3:0] dst, input logic signed [15:0] w);
    result_t none;
    none = '0;
    if ($urandom_range(9) == 0) begin
      send_request(opcode_e'($urandom_range(3)), 4'($urandom_range(15)),
                   4'($urandom_range(15)), 16'($urandom()), 1'b0, none);
    end
    send_request(op, src, dst, w, 1'b0, none);
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected dist=%0d inf=%0b neg=%0b kind=%0b,",
               what, $signed(want.distance), want.inf, want.neg, want.kind);
      $display("  got dist=%0d inf=%0b neg=%0b kind=%0b",
               $signed(got.distance), got.inf, got.neg, got.kind);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.distance = m_axis_tdata[31:0];
      got.inf      = m_axis_tdata[32];
      got.neg      = m_axis_tdata[33];
      got.kind     = result_kind_e'(m_axis_tuser[0]);
      if (pending_results.size() == 0) begin
        want = '0;
        flag_mismatch("no result pending", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.distance !== want.distance || got.inf !== want.inf ||
            got.neg !== want.neg || got.kind !== want.kind) begin
          flag_mismatch("field differs", want, got);
        end
      end
    end
  end

  initial begin
    int               nodes;
    int               seg;
    int               done;
    int               first_random;
    int               pick;
    logic signed [15:0] w;

    clear_paths();
    active_nodes = NODE_COUNT_RST;
    both_ways    = UNDIRECTED_RST;

    // Reset state, then the empty graph on all sixteen nodes.
    directed_plan.push_back(checked_row(OP_READ, 4'd0, 4'd0, 0, 0, 1'b0, 1'b0));
    directed_plan.push_back(checked_row(OP_READ, 4'd0, 4'd15, 0, 0, 1'b1, 1'b0));
    directed_plan.push_back(checked_row(OP_READ, 4'd15, 4'd15, 0, 0, 1'b0, 1'b0));
    directed_plan.push_back(checked_row(OP_COMPUTE, 4'd0, 4'd0, 0, 0, 1'b0, 1'b0));
    directed_plan.push_back(checked_row(OP_READ, 4'd15, 4'd0, 0, 0, 1'b1, 1'b0));
    // Directed edges, a negative self loop, and a compute over zero nodes.
    directed_plan.push_back(cfg_row(CFG_UNDIRECTED, 5'd0));
    directed_plan.push_back(cfg_row(CFG_NODE_COUNT, 5'd0));
    directed_plan.push_back(item_row(OP_EDGE, 4'd3, 4'd3, -32768));
    directed_plan.push_back(checked_row(OP_COMPUTE, 4'd0, 4'd0, 0, 0, 1'b0, 1'b0));
    directed_plan.push_back(checked_row(OP_READ, 4'd3, 4'd3, 0, -32768, 1'b0, 1'b0));
    directed_plan.push_back(item_row(OP_EDGE, 4'd2, 4'd5, 32767));
    directed_plan.push_back(checked_row(OP_READ, 4'd2, 4'd5, 0, 32767, 1'b0, 1'b0));
    directed_plan.push_back(checked_row(OP_READ, 4'd5, 4'd2, 0, 0, 1'b1, 1'b0));
    // A node count past the matrix size behaves as the full matrix.
    directed_plan.push_back(cfg_row(CFG_NODE_COUNT, 5'd31));
    directed_plan.push_back(checked_row(OP_COMPUTE, 4'd0, 4'd0, 0, 0, 1'b0, 1'b1));
    directed_plan.push_back(item_row(OP_READ, 4'd3, 4'd3, 0));
    directed_plan.push_back(item_row(OP_CLEAR, 4'd15, 4'd15, -1));
    directed_plan.push_back(checked_row(OP_READ, 4'd3, 4'd3, 0, 0, 1'b0, 1'b0));
    directed_plan.push_back(checked_row(OP_READ, 4'd2, 4'd5, 0, 0, 1'b1, 1'b0));
    // A negative undirected chain: repeated computes drive the sums into saturation.
    directed_plan.push_back(cfg_row(CFG_UNDIRECTED, 5'd1));
    directed_plan.push_back(cfg_row(CFG_NODE_COUNT, 5'd4));
    directed_plan.push_back(item_row(OP_EDGE, 4'd0, 4'd1, -32768));
    directed_plan.push_back(item_row(OP_EDGE, 4'd1, 4'd2, -32768));
    directed_plan.push_back(item_row(OP_EDGE, 4'd2, 4'd3, -32768));
    repeat (4) directed_plan.push_back(item_row(OP_COMPUTE, 4'd0, 4'd0, 0));
    directed_plan.push_back(item_row(OP_READ, 4'd0, 4'd3, 0));
    directed_plan.push_back(item_row(OP_READ, 4'd3, 4'd0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        write_cfg(directed_plan[r].reg_index, directed_plan[r].reg_value);
      end else begin
        send_request(directed_plan[r].op, directed_plan[r].src, directed_plan[r].dst,
                     directed_plan[r].w, directed_plan[r].typed, directed_plan[r].want);
      end
    end

    // Random graphs: most rounds are clear, edges, compute, then reads.
    first_random = items_sent;
    seg = 0;
    while (items_sent < first_random + RANDOM_ITEMS) begin
      done = items_sent - first_random;
      if (done >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (done >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 37;
      end
      // Large graphs are slow to relax, so only one segment uses all nodes.
      nodes = (seg == 0) ? 1 : (seg == 3) ? NODES : $urandom_range(2, 6);
      write_cfg(CFG_NODE_COUNT, 5'(nodes));
      write_cfg(CFG_UNDIRECTED, 5'(seg % 2));
      repeat ((nodes == NODES) ? 1 : 2) begin
        if ($urandom_range(3) != 0) begin
          send_item(OP_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    16'($urandom()));
        end
        repeat ($urandom_range(nodes, (2 * nodes > 12) ? 12 : 2 * nodes)) begin
          pick = $urandom_range(99);
          if (pick < 60) w = 16'($urandom_range(200));
          else if (pick < 85) w = -16'($urandom_range(1, 50));
          else w = 16'($urandom());
          send_item(OP_EDGE, pick_node(nodes), pick_node(nodes), w);
        end
        send_item(OP_COMPUTE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  16'($urandom()));
        repeat ($urandom_range(3, 6)) begin
          send_item(OP_READ, pick_node(nodes), pick_node(nodes), 16'($urandom()));
        end
      end
      seg++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- all_pairs_shortest_path_top.f -----
rtl/core/apsp_pkg.sv
rtl/core/apsp_mem.sv
rtl/core/apsp_relax.sv
rtl/core/apsp_seq.sv
rtl/core/all_pairs_shortest_path_top.sv
rtl/core/apsp_checker.sv
tb/tb_top.sv
